// File: rtl/mstd_pkg.sv
// Shared types and constants for the magnetic stripe track decoder.
// Used by magstripe_track_decoder; depends on nothing else.
package mstd_pkg;

    localparam int CHAR_W = 8;
    localparam int CNT_W  = 8;

    localparam logic [3:0] CHAR_BITS_MIN = 4'd5;

    // decoder phases
    localparam logic [2:0] PH_SEARCH = 3'd0;
    localparam logic [2:0] PH_DATA   = 3'd1;
    localparam logic [2:0] PH_LRC    = 3'd2;
    localparam logic [2:0] PH_TRAIL  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_CHAR_BITS   = 3'd0;
    localparam logic [2:0] CFG_START_CODE  = 3'd1;
    localparam logic [2:0] CFG_STOP_CODE   = 3'd2;
    localparam logic [2:0] CFG_ODD_PARITY  = 3'd3;
    localparam logic [2:0] CFG_LRC_START   = 3'd4;
    localparam logic [2:0] CFG_MIN_ONES    = 3'd5;

    // configuration reset values
    localparam logic [3:0]        RST_CHAR_BITS  = 4'd5;
    localparam logic [CHAR_W-1:0] RST_START_CODE = 8'h0B;
    localparam logic [CHAR_W-1:0] RST_STOP_CODE  = 8'h1F;
    localparam logic              RST_ODD_PARITY = 1'b1;
    localparam logic              RST_LRC_START  = 1'b1;
    localparam logic [CNT_W-1:0]  RST_MIN_ONES   = 8'd8;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] char_value;
        logic              char_parity_ok;
        logic              start_found;
        logic              stop_found;
        logic              lrc_ok;
        logic              all_parity_ok;
        logic              frame_error;
        logic [CNT_W-1:0]  char_count;
        logic              last_result;
    } result_t;

    function automatic logic parity_good(input logic [CHAR_W-1:0] ch, input logic odd);
        parity_good = ((^ch) == odd);
    endfunction

endpackage

// File: rtl/magstripe_track_decoder.sv
// Magnetic stripe track decoder top level: sentinel search, character
// packing, parity and LRC checks, and a four-entry result queue. Uses mstd_pkg.
//
// Takes one track bit per beat and accepts a new bit every cycle while the
// result queue has room for two results; a bit is fully decoded in the cycle
// it is accepted, and its results (a data character, the end-of-track status,
// or both, data first) are queued and reach the m_ side in order. Throughput
// is one bit per cycle, set only by the result queue draining one result per
// cycle; s_ready drops when fewer than two queue entries are free.
// Configuration writes are taken at any time (cfg_ready is always high) and
// must only be issued while no track bit is outstanding. After the bit marked
// last, the track state clears and the configuration is kept.
module magstripe_track_decoder #(
    parameter int MAX_CHAR_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [7:0]                cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_bit_req,
    input  logic                      s_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_kind,
    output logic [mstd_pkg::CHAR_W-1:0] m_char_value,
    output logic                      m_char_parity_ok,
    output logic                      m_start_found,
    output logic                      m_stop_found,
    output logic                      m_lrc_ok,
    output logic                      m_all_parity_ok,
    output logic                      m_frame_error,
    output logic [mstd_pkg::CNT_W-1:0] m_char_count,
    output logic                      m_last_result
);
    import mstd_pkg::*;

    localparam logic [3:0] MAX_CB = 4'(MAX_CHAR_BITS);
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // configuration
    logic [3:0]        char_bits_reg;
    logic [CHAR_W-1:0] start_code_reg;
    logic [CHAR_W-1:0] stop_code_reg;
    logic              odd_parity_reg;
    logic              lrc_start_reg;
    logic [CNT_W-1:0]  min_ones_reg;

    // track state
    logic [2:0]        phase_reg, phase_next;
    logic [CHAR_W-1:0] window_reg, window_next;
    logic [2:0]        bit_index_reg, bit_index_next;
    logic [CHAR_W-1:0] lrc_acc_reg, lrc_acc_next;
    logic              fl_start_reg, fl_start_next;
    logic              fl_stop_reg, fl_stop_next;
    logic              fl_lrc_reg, fl_lrc_next;
    logic              fl_par_reg, fl_par_next;
    logic              fl_trail_reg, fl_trail_next;
    logic [CNT_W-1:0]  data_count_reg, data_count_next;
    logic [CNT_W-1:0]  ones_seen_reg, ones_seen_next;

    // result queue
    result_t           queue_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    logic              s_accept, m_accept;
    logic [3:0]        c_eff;
    logic [3:0]        c_m1;
    logic [CHAR_W-1:0] lrc_mask;
    logic              data_push, stat_push;
    result_t           data_res, stat_res;

    assign cfg_ready = 1'b1;
    assign s_ready   = (count_reg <= (QPTR_W+1)'(QDEPTH - 2));
    assign s_accept  = s_valid && s_ready;
    assign m_valid   = (count_reg != '0);
    assign m_accept  = m_valid && m_ready;

    assign c_eff    = (char_bits_reg < CHAR_BITS_MIN) ? CHAR_BITS_MIN :
                      (char_bits_reg > MAX_CB) ? MAX_CB : char_bits_reg;
    assign c_m1     = c_eff - 4'd1;
    assign lrc_mask = (CHAR_W'(1) << c_m1[2:0]) - CHAR_W'(1);

    always_comb begin
        logic [CHAR_W-1:0] ch_v;
        logic              pok_v;
        phase_next      = phase_reg;
        window_next     = window_reg;
        bit_index_next  = bit_index_reg;
        lrc_acc_next    = lrc_acc_reg;
        fl_start_next   = fl_start_reg;
        fl_stop_next    = fl_stop_reg;
        fl_lrc_next     = fl_lrc_reg;
        fl_par_next     = fl_par_reg;
        fl_trail_next   = fl_trail_reg;
        data_count_next = data_count_reg;
        ones_seen_next  = ones_seen_reg;
        data_push       = 1'b0;
        stat_push       = 1'b0;
        data_res        = '0;
        stat_res        = '0;
        ch_v            = '0;
        pok_v           = 1'b0;

        if (s_bit_req && ones_seen_reg != '1) begin
            ones_seen_next = ones_seen_reg + CNT_W'(1);
        end

        if (phase_reg == PH_SEARCH) begin
            window_next = (window_reg >> 1) | (CHAR_W'(s_bit_req) << c_m1[2:0]);
            if (window_next == start_code_reg) begin
                fl_start_next  = 1'b1;
                lrc_acc_next   = lrc_start_reg ? window_next : '0;
                window_next    = '0;
                bit_index_next = '0;
                phase_next     = PH_DATA;
            end
        end else if (phase_reg != PH_DONE) begin
            window_next = window_reg | (CHAR_W'(s_bit_req) << bit_index_reg);
            if ({1'b0, bit_index_reg} >= c_m1) begin
                ch_v           = window_next;
                window_next    = '0;
                bit_index_next = '0;
                case (phase_reg)
                    PH_DATA: begin
                        if (ch_v == '0) begin
                            phase_next = PH_TRAIL;
                        end else begin
                            pok_v        = parity_good(ch_v, odd_parity_reg);
                            lrc_acc_next = lrc_acc_reg ^ ch_v;
                            if (!pok_v) begin
                                fl_par_next = 1'b0;
                            end
                            if (ch_v == stop_code_reg) begin
                                fl_stop_next = 1'b1;
                                phase_next   = PH_LRC;
                            end else begin
                                if (data_count_reg != '1) begin
                                    data_count_next = data_count_reg + CNT_W'(1);
                                end
                                data_push               = 1'b1;
                                data_res.kind           = KIND_DATA;
                                data_res.char_value     = ch_v;
                                data_res.char_parity_ok = pok_v;
                            end
                        end
                    end
                    PH_LRC: begin
                        if (!parity_good(ch_v, odd_parity_reg)) begin
                            fl_par_next = 1'b0;
                        end
                        if (((lrc_acc_reg ^ ch_v) & lrc_mask) == '0) begin
                            fl_lrc_next = 1'b1;
                        end
                        phase_next = PH_TRAIL;
                    end
                    default: begin
                        if (ch_v != '0) begin
                            fl_trail_next = 1'b1;
                        end
                        phase_next = PH_DONE;
                    end
                endcase
            end else begin
                bit_index_next = bit_index_reg + 3'd1;
            end
        end

        if (s_last) begin
            // complete a partial LRC or trailing character with zeros
            if (phase_next == PH_LRC) begin
                if (!parity_good(window_next, odd_parity_reg)) begin
                    fl_par_next = 1'b0;
                end
                if (((lrc_acc_next ^ window_next) & lrc_mask) == '0) begin
                    fl_lrc_next = 1'b1;
                end
                phase_next  = PH_TRAIL;
                window_next = '0;
            end
            if (phase_next == PH_TRAIL && window_next != '0) begin
                fl_trail_next = 1'b1;
            end
            stat_push            = 1'b1;
            stat_res.kind        = KIND_STATUS;
            stat_res.last_result = 1'b1;
            if (ones_seen_next <= min_ones_reg) begin
                stat_res.all_parity_ok = 1'b1;
            end else begin
                stat_res.start_found   = fl_start_next;
                stat_res.stop_found    = fl_stop_next;
                stat_res.lrc_ok        = fl_lrc_next;
                stat_res.all_parity_ok = fl_par_next;
                stat_res.frame_error   = !(fl_par_next && fl_stop_next && fl_lrc_next
                                           && !fl_trail_next);
                stat_res.char_count    = data_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_bits_reg  <= RST_CHAR_BITS;
            start_code_reg <= RST_START_CODE;
            stop_code_reg  <= RST_STOP_CODE;
            odd_parity_reg <= RST_ODD_PARITY;
            lrc_start_reg  <= RST_LRC_START;
            min_ones_reg   <= RST_MIN_ONES;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CHAR_BITS:  char_bits_reg  <= cfg_data[3:0];
                CFG_START_CODE: start_code_reg <= cfg_data;
                CFG_STOP_CODE:  stop_code_reg  <= cfg_data;
                CFG_ODD_PARITY: odd_parity_reg <= cfg_data[0];
                CFG_LRC_START:  lrc_start_reg  <= cfg_data[0];
                CFG_MIN_ONES:   min_ones_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (s_accept && s_last)) begin
            phase_reg      <= PH_SEARCH;
            window_reg     <= '0;
            bit_index_reg  <= '0;
            lrc_acc_reg    <= '0;
            fl_start_reg   <= 1'b0;
            fl_stop_reg    <= 1'b0;
            fl_lrc_reg     <= 1'b0;
            fl_par_reg     <= 1'b1;
            fl_trail_reg   <= 1'b0;
            data_count_reg <= '0;
            ones_seen_reg  <= '0;
        end else if (s_accept) begin
            phase_reg      <= phase_next;
            window_reg     <= window_next;
            bit_index_reg  <= bit_index_next;
            lrc_acc_reg    <= lrc_acc_next;
            fl_start_reg   <= fl_start_next;
            fl_stop_reg    <= fl_stop_next;
            fl_lrc_reg     <= fl_lrc_next;
            fl_par_reg     <= fl_par_next;
            fl_trail_reg   <= fl_trail_next;
            data_count_reg <= data_count_next;
            ones_seen_reg  <= ones_seen_next;
        end
    end

    // result queue: push data then status, pop one beat per cycle while m_ready is high
    always_ff @(posedge aclk) begin
        if (s_accept && data_push) begin
            queue_reg[wr_ptr_reg] <= data_res;
        end
        if (s_accept && stat_push) begin
            queue_reg[wr_ptr_reg + QPTR_W'(data_push)] <= stat_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (s_accept) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(data_push) + QPTR_W'(stat_push);
            end
            if (m_accept) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg
                         + (QPTR_W+1)'(s_accept && data_push)
                         + (QPTR_W+1)'(s_accept && stat_push)
                         - (QPTR_W+1)'(m_accept);
        end
    end

    assign m_kind           = queue_reg[rd_ptr_reg].kind;
    assign m_char_value     = queue_reg[rd_ptr_reg].char_value;
    assign m_char_parity_ok = queue_reg[rd_ptr_reg].char_parity_ok;
    assign m_start_found    = queue_reg[rd_ptr_reg].start_found;
    assign m_stop_found     = queue_reg[rd_ptr_reg].stop_found;
    assign m_lrc_ok         = queue_reg[rd_ptr_reg].lrc_ok;
    assign m_all_parity_ok  = queue_reg[rd_ptr_reg].all_parity_ok;
    assign m_frame_error    = queue_reg[rd_ptr_reg].frame_error;
    assign m_char_count     = queue_reg[rd_ptr_reg].char_count;
    assign m_last_result    = queue_reg[rd_ptr_reg].last_result;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("result queue overflow");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_last |=> m_valid)
        else $error("no result after last beat");

    a_status_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_result |-> m_kind == KIND_STATUS)
        else $error("last result is not a status beat");

    a_search_index: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SEARCH |-> bit_index_reg == 3'd0)
        else $error("bit index moved during sentinel search");

endmodule
